>>> sv/trv_pkg.sv
// Shared constants and codes for the trail vertex attribute pipeline.
package trv_pkg;

    // Q1.16 one and related widths
    localparam int             AGE_W    = 17;
    localparam logic [16:0]    ONE_Q16  = 17'd65536;

    // Age divider: quotient bits resolved per stage and number of stages
    localparam int DIV_STEP   = 2;
    localparam int DIV_QBITS  = 16;
    localparam int DIV_STAGES = DIV_QBITS / DIV_STEP;

    // Head factor: age scaled by 1/0.08, reciprocal of the 0.08 point in Q16
    localparam logic [12:0]    HEAD_SOFT   = 13'd5243;
    localparam logic [19:0]    HEAD_RECIP  = 20'd819181;
    localparam logic [17:0]    SMOOTH_3    = 18'd196608;

    // Width and opacity head blends (0.35 + 0.65 h, 0.4 + 0.6 h)
    localparam logic [16:0]    W_BASE = 17'd22938;
    localparam logic [15:0]    W_SPAN = 16'd42598;
    localparam logic [16:0]    O_BASE = 17'd26214;
    localparam logic [15:0]    O_SPAN = 16'd39322;

    // Lower limits on divisor and exponent
    localparam logic [15:0]    MIN_LENGTH = 16'd205;
    localparam logic [15:0]    MIN_FADE   = 16'd205;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAIL_LENGTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_WIDTH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAPER_AMOUNT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_COLOR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL_COLOR    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_OPACITY  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_EXPONENT = 3'd7;

endpackage

>>> sv/trail_vertex_attributes_top.sv
// Top level of the trail vertex attribute pipeline.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-----------------------------------------------
//   input    | i_valid / o_stall  | i_pos_x/y/z, i_current_time, i_sample_time,
//            |                    | i_end_of_points
//   output   | o_valid / i_stall  | o_out_x/y/z, o_point_width, o_color_*,
//            |                    | o_point_opacity, o_end_of_strip
//   config   | i_cfg_we           | i_cfg_index, i_cfg_data
//
// One point per cycle is taken while the output is not stalled; each point passes from
// transfer in to result through the elapsed-time register, the 9-stage age divider,
// the 10-stage power unit and two final product stages in series.
// Synchronous active-low reset clears valid bits and loads register defaults.
// A stalled result freezes the whole pipeline; o_stall follows o_valid & i_stall.
module trail_vertex_attributes_top
    import trv_pkg::*;
#(
    parameter int POW_TABLE_DEPTH = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [47:0]          i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic signed [31:0]   i_pos_x,
    input  logic signed [31:0]   i_pos_y,
    input  logic signed [31:0]   i_pos_z,
    input  logic [47:0]          i_current_time,
    input  logic [47:0]          i_sample_time,
    input  logic                 i_end_of_points,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [31:0]   o_out_x,
    output logic signed [31:0]   o_out_y,
    output logic signed [31:0]   o_out_z,
    output logic [21:0]          o_point_width,
    output logic [23:0]          o_color_red,
    output logic [23:0]          o_color_green,
    output logic [23:0]          o_color_blue,
    output logic [16:0]          o_point_opacity,
    output logic                 o_end_of_strip
);

    localparam int DIV_LAT = DIV_STAGES + 1;
    localparam int NA      = 12;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               eop;
    } t_side;

    typedef struct packed {
        t_side              side;
        logic [16:0]        age;
        logic [16:0]        hq0;
        logic               hbig;
        logic [28:0]        hm;
        logic [16:0]        t1;
        logic [2:0][15:0]   mix;
        logic [21:0]        w1;
        logic [2:0][23:0]   col;
        logic [16:0]        h;
        logic [16:0]        hh;
        logic [16:0]        head;
        logic [16:0]        wf;
        logic [16:0]        opf;
        logic [16:0]        op1;
        logic [21:0]        width;
        logic [16:0]        opac;
    } t_stage;

    // Configuration registers
    logic [15:0] r_trail_length;
    logic [21:0] r_head_width;
    logic [16:0] r_taper_amount;
    logic [47:0] r_head_color;
    logic [47:0] r_tail_color;
    logic [15:0] r_brightness;
    logic [16:0] r_head_opacity;
    logic [15:0] r_fade_exponent;

    logic [15:0] w_len;
    logic [16:0] w_taper;
    logic [16:0] w_opa;
    logic [15:0] w_fade;

    logic               w_en;
    logic [47:0]        r_diff;
    t_side              r_sd [0:DIV_LAT];
    logic [DIV_LAT:0]   r_vd;
    t_stage             r_a  [1:NA];
    t_stage             n_a  [1:NA];
    logic [NA:1]        r_va;
    logic [AGE_W-1:0]   w_age;
    logic [16:0]        w_base;
    logic [16:0]        w_pw;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trail_length  <= 16'd4915;
            r_head_width    <= 22'd32768;
            r_taper_amount  <= 17'd55706;
            r_head_color    <= 48'hFFFF_D999_599A;
            r_tail_color    <= 48'hFFFF_3333_8CCC;
            r_brightness    <= 16'd768;
            r_head_opacity  <= 17'd39322;
            r_fade_exponent <= 16'd6144;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TRAIL_LENGTH:  r_trail_length  <= i_cfg_data[15:0];
                CFG_HEAD_WIDTH:    r_head_width    <= i_cfg_data[21:0];
                CFG_TAPER_AMOUNT:  r_taper_amount  <= i_cfg_data[16:0];
                CFG_HEAD_COLOR:    r_head_color    <= i_cfg_data;
                CFG_TAIL_COLOR:    r_tail_color    <= i_cfg_data;
                CFG_BRIGHTNESS:    r_brightness    <= i_cfg_data[15:0];
                CFG_HEAD_OPACITY:  r_head_opacity  <= i_cfg_data[16:0];
                CFG_FADE_EXPONENT: r_fade_exponent <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Clamp registers into their working ranges
    assign w_len   = (r_trail_length < MIN_LENGTH) ? MIN_LENGTH : r_trail_length;
    assign w_taper = (r_taper_amount > ONE_Q16) ? ONE_Q16 : r_taper_amount;
    assign w_opa   = (r_head_opacity > ONE_Q16) ? ONE_Q16 : r_head_opacity;
    assign w_fade  = (r_fade_exponent < MIN_FADE) ? MIN_FADE : r_fade_exponent;

    // Advance everything unless a result is held
    assign w_en    = !r_va[NA] || !i_stall;
    assign o_stall = !w_en;

    // Take the input transfer and form the elapsed time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd <= '0;
        end else if (w_en) begin
            r_vd <= {r_vd[DIV_LAT-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_diff <= (i_current_time > i_sample_time) ?
                      (i_current_time - i_sample_time) : 48'd0;
            r_sd[0] <= '{x: i_pos_x, y: i_pos_y, z: i_pos_z, eop: i_end_of_points};
            for (int k = 1; k <= DIV_LAT; k++) r_sd[k] <= r_sd[k-1];
        end
    end

    trv_age_div u_div (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_diff (r_diff),
        .i_len  (w_len),
        .o_age  (w_age)
    );

    assign w_base = ONE_Q16 - w_age;

    trv_pow #(
        .DEPTH (POW_TABLE_DEPTH)
    ) u_pow (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_base (w_base),
        .i_fade (w_fade),
        .o_pow  (w_pw)
    );

    // Attribute stages
    always_comb begin
        logic [32:0] v_hq;
        logic [33:0] v_tp;
        logic [33:0] v_mix;
        logic [29:0] v_hm;
        logic [38:0] v_w1;
        logic [31:0] v_c;
        logic [28:0] v_rem;
        logic [33:0] v_hh;
        logic [17:0] v_fac;
        logic [34:0] v_hd;
        logic [32:0] v_ws;
        logic [32:0] v_os;
        logic [38:0] v_wd;
        logic [33:0] v_o1;
        logic [33:0] v_o2;

        n_a[1] = '0;
        for (int k = 2; k <= NA; k++) n_a[k] = r_a[k-1];

        // Age, first head quotient, taper term, colour blend
        n_a[1].side = r_sd[DIV_LAT];
        n_a[1].age  = w_age;
        v_hq        = w_age[12:0] * HEAD_RECIP;
        n_a[1].hq0  = v_hq[32:16];
        n_a[1].hbig = w_age >= {4'b0, HEAD_SOFT};
        v_tp        = w_taper * w_age;
        n_a[1].t1   = v_tp[32:16];
        for (int c = 0; c < 3; c++) begin
            v_mix = r_head_color[16*c +: 16] * (ONE_Q16 - w_age)
                  + r_tail_color[16*c +: 16] * w_age;
            n_a[1].mix[c] = v_mix[31:16];
        end

        // Quotient check product, tapered width, brightness; product stays in range
        v_hm       = r_a[1].hq0 * HEAD_SOFT;
        n_a[2].hm  = v_hm[28:0];
        v_w1       = r_head_width * (ONE_Q16 - r_a[1].t1);
        n_a[2].w1  = v_w1[37:16];
        for (int c = 0; c < 3; c++) begin
            v_c = r_a[1].mix[c] * r_brightness;
            n_a[2].col[c] = v_c[31:8];
        end

        // Correct the head quotient by one where needed; ages at or past the head point give one
        v_rem = {r_a[2].age[12:0], 16'b0} - r_a[2].hm;
        if (r_a[2].hbig) begin
            n_a[3].h = ONE_Q16;
        end else if (v_rem >= {16'b0, HEAD_SOFT}) begin
            n_a[3].h = r_a[2].hq0 + 17'd1;
        end else begin
            n_a[3].h = r_a[2].hq0;
        end

        // Smoothstep
        v_hh        = r_a[3].h * r_a[3].h;
        n_a[4].hh   = v_hh[32:16];
        v_fac       = SMOOTH_3 - {r_a[4].h, 1'b0};
        v_hd        = r_a[4].hh * v_fac;
        n_a[5].head = v_hd[32:16];

        // Head blends for width and opacity
        v_ws       = W_SPAN * r_a[5].head;
        n_a[6].wf  = W_BASE + v_ws[32:16];
        v_os       = O_SPAN * r_a[5].head;
        n_a[6].opf = O_BASE + v_os[32:16];

        // Final width and opacity, power arrives beside stage ten
        v_wd         = r_a[10].w1 * r_a[10].wf;
        n_a[11].width = v_wd[37:16];
        v_o1         = w_opa * w_pw;
        n_a[11].op1  = v_o1[32:16];
        v_o2         = r_a[11].op1 * r_a[11].opf;
        n_a[12].opac = v_o2[32:16];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= '0;
        end else if (w_en) begin
            r_va <= {r_va[NA-1:1], r_vd[DIV_LAT]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 1; k <= NA; k++) r_a[k] <= n_a[k];
        end
    end

    assign o_valid         = r_va[NA];
    assign o_out_x         = r_a[NA].side.x;
    assign o_out_y         = r_a[NA].side.y;
    assign o_out_z         = r_a[NA].side.z;
    assign o_end_of_strip  = r_a[NA].side.eop;
    assign o_point_width   = r_a[NA].width;
    assign o_color_red     = r_a[NA].col[0];
    assign o_color_green   = r_a[NA].col[1];
    assign o_color_blue    = r_a[NA].col[2];
    assign o_point_opacity = r_a[NA].opac;

endmodule

>>> sv/trv_age_div.sv
// Pipelined restoring divider that turns elapsed time into clamped Q1.16 age.
module trv_age_div
    import trv_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [47:0]      i_diff,
    input  logic [15:0]      i_len,
    output logic [AGE_W-1:0] o_age
);

    logic [DIV_STAGES:0][15:0] r_rem;
    logic [DIV_STAGES:0][15:0] r_low;
    logic [DIV_STAGES:0][15:0] r_q;
    logic [DIV_STAGES:0]       r_sat;
    logic [DIV_STAGES:1][15:0] n_rem;
    logic [DIV_STAGES:1][15:0] n_low;
    logic [DIV_STAGES:1][15:0] n_q;

    // Resolve DIV_STEP quotient bits per stage
    always_comb begin
        logic [15:0] v_r;
        logic [15:0] v_l;
        logic [15:0] v_q;
        logic [16:0] v_t;
        for (int s = 1; s <= DIV_STAGES; s++) begin
            v_r = r_rem[s-1];
            v_l = r_low[s-1];
            v_q = r_q[s-1];
            for (int j = 0; j < DIV_STEP; j++) begin
                v_t = {v_r, v_l[15]};
                v_l = {v_l[14:0], 1'b0};
                if (v_t >= {1'b0, i_len}) begin
                    v_t = v_t - {1'b0, i_len};
                    v_q = {v_q[14:0], 1'b1};
                end else begin
                    v_q = {v_q[14:0], 1'b0};
                end
                v_r = v_t[15:0];
            end
            n_rem[s] = v_r;
            n_low[s] = v_l;
            n_q[s]   = v_q;
        end
    end

    // Load dividend diff * 4096; flag ages that clamp to one
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sat[0] <= i_diff >= {28'b0, i_len, 4'b0};
            r_rem[0] <= i_diff[19:4];
            r_low[0] <= {i_diff[3:0], 12'b0};
            r_q[0]   <= '0;
            for (int s = 1; s <= DIV_STAGES; s++) begin
                r_sat[s] <= r_sat[s-1];
                r_rem[s] <= n_rem[s];
                r_low[s] <= n_low[s];
                r_q[s]   <= n_q[s];
            end
        end
    end

    assign o_age = r_sat[DIV_STAGES] ? ONE_Q16 : {1'b0, r_q[DIV_STAGES]};

endmodule

>>> sv/trv_pow.sv
// Pipelined fixed-point power b^fade through log2 and exp2 tables.
module trv_pow
    import trv_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [16:0] i_base,
    input  logic [15:0] i_fade,
    output logic [16:0] o_pow
);

    localparam int TAB_AW = $clog2(DEPTH + 1);
    localparam int POS_W  = 16 + TAB_AW;
    localparam logic [TAB_AW-1:0] DEPTH_V = TAB_AW'(DEPTH);

    typedef logic [16:0] t_tab [0:DEPTH];

    function automatic longint unsigned f_isqrt(longint unsigned v_in);
        longint unsigned v;
        longint unsigned r;
        longint unsigned b;
        v = v_in;
        r = 0;
        b = 64'd1 << 62;
        for (int j = 0; j < 32; j++) begin
            if (b > v) b = b >> 2;
        end
        for (int j = 0; j < 32; j++) begin
            if (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // log2 of a Q16 value in [1,2] by repeated squaring
    function automatic logic [16:0] f_log2_unit(longint unsigned x);
        longint unsigned v;
        longint unsigned res;
        v   = x << 14;
        res = 0;
        if (v >= (64'd1 << 31)) return ONE_Q16;
        for (int k = 0; k < 16; k++) begin
            v   = (v * v) >> 30;
            res = res << 1;
            if (v >= (64'd1 << 31)) begin
                res = res | 64'd1;
                v   = v >> 1;
            end
        end
        return res[16:0];
    endfunction

    function automatic t_tab f_log_tab();
        t_tab            tab;
        longint unsigned y;
        for (int i = 0; i <= DEPTH; i++) begin
            y      = (longint'(i) * 65536) / DEPTH;
            tab[i] = f_log2_unit(65536 + y);
        end
        return tab;
    endfunction

    function automatic t_tab f_exp_tab();
        t_tab            tab;
        longint unsigned roots [16];
        longint unsigned r;
        longint unsigned y;
        longint unsigned rr;
        roots[0] = f_isqrt(64'd1 << 59);
        for (int k = 1; k < 16; k++) roots[k] = f_isqrt(roots[k-1] << 30);
        for (int i = 0; i <= DEPTH; i++) begin
            y = (longint'(i) * 65536) / DEPTH;
            if (y >= 65536) begin
                tab[i] = 17'd32768;
            end else begin
                r = 64'd1 << 30;
                for (int k = 0; k < 16; k++) begin
                    if (((y >> (15 - k)) & 64'd1) != 0) r = (r * roots[k]) >> 30;
                end
                rr     = (r + 64'd8192) >> 14;
                tab[i] = rr[16:0];
            end
        end
        return tab;
    endfunction

    localparam t_tab LOG_TAB = f_log_tab();
    localparam t_tab EXP_TAB = f_exp_tab();

    // Stage registers
    logic              r_one0, r_zero0;
    logic [4:0]        r_sh0;
    logic [15:0]       r_f0;
    logic              r_one1, r_zero1;
    logic [4:0]        r_sh1;
    logic [TAB_AW-1:0] r_idx1;
    logic [15:0]       r_fr1;
    logic              r_one2, r_zero2;
    logic [4:0]        r_sh2;
    logic [16:0]       r_l0, r_l1;
    logic [15:0]       r_fr2;
    logic              r_one3, r_zero3;
    logic [4:0]        r_sh3;
    logic [16:0]       r_lg3;
    logic              r_one4, r_zero4;
    logic [20:0]       r_nl4;
    logic              r_one5, r_zero5;
    logic [24:0]       r_prod5;
    logic              r_one6, r_zero6, r_big6;
    logic [4:0]        r_n6;
    logic [TAB_AW-1:0] r_idx6;
    logic [15:0]       r_fr6;
    logic              r_one7, r_zero7, r_big7;
    logic [4:0]        r_n7;
    logic [16:0]       r_e0, r_e1;
    logic [15:0]       r_fr7;
    logic              r_one8, r_zero8, r_big8;
    logic [4:0]        r_n8;
    logic [16:0]       r_e8;
    logic [16:0]       r_pow9;

    logic [4:0]        w_p;
    logic [4:0]        w_sh;
    logic [31:0]       w_mant;
    logic [POS_W-1:0]  w_pos1, w_pos6;
    logic [32:0]       w_ld;
    logic [16:0]       w_lg;
    logic [20:0]       w_nw;
    logic [36:0]       w_pr;
    logic [8:0]        w_n;
    logic [16:0]       w_ed;
    logic [32:0]       w_ep;
    logic [16:0]       w_e;

    // Find the leading one and normalise the mantissa
    always_comb begin
        w_p = '0;
        for (int k = 0; k < 16; k++) begin
            if (i_base[k]) w_p = 5'(k);
        end
        w_sh   = 5'd16 - w_p;
        w_mant = {16'b0, i_base[15:0]} << w_sh;
    end

    // Interpolate, scale by the exponent and interpolate back
    always_comb begin
        w_pos1 = r_f0 * DEPTH_V;
        w_ld   = (r_l1 - r_l0) * r_fr2;
        w_lg   = r_l0 + w_ld[32:16];
        w_nw   = {r_sh3, 16'b0};
        w_pr   = r_nl4 * i_fade;
        w_n    = r_prod5[24:16];
        w_pos6 = r_prod5[15:0] * DEPTH_V;
        w_ed   = r_e0 - r_e1;
        w_ep   = w_ed * r_fr7;
        w_e    = (r_e1 < r_e0) ? (r_e0 - w_ep[32:16]) : r_e0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_one0  <= i_base[16];
            r_zero0 <= i_base == 17'd0;
            r_sh0   <= w_sh;
            r_f0    <= w_mant[15:0];

            // f < 1 keeps the index below DEPTH
            r_one1  <= r_one0;
            r_zero1 <= r_zero0;
            r_sh1   <= r_sh0;
            r_idx1  <= w_pos1[POS_W-1:16];
            r_fr1   <= w_pos1[15:0];

            r_one2  <= r_one1;
            r_zero2 <= r_zero1;
            r_sh2   <= r_sh1;
            r_l0    <= LOG_TAB[r_idx1];
            r_l1    <= LOG_TAB[TAB_AW'(r_idx1 + 1'b1)];
            r_fr2   <= r_fr1;

            r_one3  <= r_one2;
            r_zero3 <= r_zero2;
            r_sh3   <= r_sh2;
            r_lg3   <= w_lg;

            r_one4  <= r_one3;
            r_zero4 <= r_zero3;
            r_nl4   <= (w_nw > {4'b0, r_lg3}) ? (w_nw - {4'b0, r_lg3}) : 21'd0;

            r_one5  <= r_one4;
            r_zero5 <= r_zero4;
            r_prod5 <= w_pr[36:12];

            r_one6  <= r_one5;
            r_zero6 <= r_zero5;
            r_big6  <= w_n >= 9'd17;
            r_n6    <= w_n[4:0];
            r_idx6  <= w_pos6[POS_W-1:16];
            r_fr6   <= w_pos6[15:0];

            r_one7  <= r_one6;
            r_zero7 <= r_zero6;
            r_big7  <= r_big6;
            r_n7    <= r_n6;
            r_e0    <= EXP_TAB[r_idx6];
            r_e1    <= EXP_TAB[TAB_AW'(r_idx6 + 1'b1)];
            r_fr7   <= r_fr6;

            r_one8  <= r_one7;
            r_zero8 <= r_zero7;
            r_big8  <= r_big7;
            r_n8    <= r_n7;
            r_e8    <= w_e;

            // Apply the integer part of the exponent and the end cases
            if (r_one8) begin
                r_pow9 <= ONE_Q16;
            end else if (r_zero8 || r_big8) begin
                r_pow9 <= '0;
            end else begin
                r_pow9 <= r_e8 >> r_n8;
            end
        end
    end

    assign o_pow = r_pow9;

endmodule

>>> sv/trv_checker.sv
// Port-level checks for the trail vertex attribute top level.
module trv_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [31:0] o_out_x,
    input logic [21:0]        o_point_width,
    input logic [16:0]        o_point_opacity,
    input logic               o_end_of_strip
);

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_x) && $stable(o_point_width)
            && $stable(o_point_opacity) && $stable(o_end_of_strip))
        else $error("stalled result changed");

    // Input stalls exactly while a result is held
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("input stall does not follow output hold");

    // Opacity never exceeds one
    a_opac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_point_opacity <= 17'd65536)
        else $error("opacity above one");

    // Reset empties the pipeline
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("pipeline not empty after reset");

endmodule

bind trail_vertex_attributes_top trv_checker u_trv_checker (.*);
